// File: sv/gsp_pkg.sv
package gsp_pkg;

	// Default geometry
	localparam int OUT_SIZE_DEF = 16;
	localparam int MAX_SIDE_DEF = 1024;

	// Fixed field widths
	localparam int CFG_W      = 11;
	localparam int ROW_BITS_W = 16;
	localparam int ROW_IDX_W  = 4;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Register reset values and register indexes
	localparam logic [CFG_W-1:0] GLYPH_SIZE_RST = 11'd16;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Command queue depth, a power of two
	localparam int FIFO_DEPTH = 4;

	// Front sequencer: scale search, pad split, pixel run
	typedef enum logic [1:0] {
		FR_SCALE,
		FR_PAD,
		FR_RUN
	} fr_state_t;

	// Back sequencer: grid update or row dump
	typedef enum logic {
		BK_RUN,
		BK_DUMP
	} bk_state_t;

	// Command flags carried through the queue
	typedef struct packed {
		logic hit;
		logic eof;
	} gsp_flags_t;

endpackage

// File: sv/gsp_fifo.sv
module gsp_fifo #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              flush,
	input  logic              push,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              pop,
	output logic [DATA_W-1:0] rd_data,
	output logic              full,
	output logic              empty
);

	localparam int AW = $clog2(gsp_pkg::FIFO_DEPTH);

	logic [DATA_W-1:0] mem_q [gsp_pkg::FIFO_DEPTH];
	logic [AW:0]       wr_ptr_q;
	logic [AW:0]       rd_ptr_q;

	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign rd_data = mem_q[rd_ptr_q[AW-1:0]];

	// Advance pointers, drop everything on flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else if (flush) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q[AW-1:0]] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !flush |-> !full)
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !flush |-> !empty)
		else $error("command popped from an empty queue");

endmodule

// File: sv/gsp_front.sv
module gsp_front #(
	parameter int OUT_SIZE = gsp_pkg::OUT_SIZE_DEF,
	parameter int MAX_SIDE = gsp_pkg::MAX_SIDE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   restart,
	input  logic [DIMV_W-1:0]      glyph_w,
	input  logic [DIMV_W-1:0]      glyph_h,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   pixel,
	input  logic                   fifo_full,
	output logic                   push,
	output gsp_pkg::gsp_flags_t    cmd_flags,
	output logic [CELL_W-1:0]      cmd_row,
	output logic [CELL_W-1:0]      cmd_col
);

	localparam int DIMV_W    = $clog2(MAX_SIDE + 1);
	localparam int DIM_W     = $clog2(MAX_SIDE);
	localparam int SIDE_W    = $clog2(MAX_SIDE + OUT_SIZE);
	localparam int MAX_SCALE = (MAX_SIDE + OUT_SIZE - 1) / OUT_SIZE;
	localparam int SC_W      = $clog2(MAX_SCALE + 1);
	localparam int CELL_W    = $clog2(OUT_SIZE);
	localparam int CELLC_W   = $clog2(OUT_SIZE + 1);

	gsp_pkg::fr_state_t state_q, state_d;

	logic [SC_W-1:0]    scale_q;
	logic [SIDE_W-1:0]  side_q;
	logic [SIDE_W-1:0]  lrem_q, trem_q;
	logic [CELLC_W-1:0] lq_q, tq_q;
	logic [DIM_W-1:0]   col_cnt_q, row_cnt_q;
	logic [SC_W-1:0]    col_sub_q, row_sub_q;
	logic [CELLC_W-1:0] col_cell_q, row_cell_q;

	logic [DIMV_W-1:0] max_dim;
	logic              grow;
	logic              pad_done;
	logic              accept;
	logic              col_last, row_last;
	logic              col_sub_last, row_sub_last;
	logic              hit;

	assign max_dim  = (glyph_w > glyph_h) ? glyph_w : glyph_h;
	assign grow     = side_q < SIDE_W'(max_dim);
	assign pad_done = (lrem_q < SIDE_W'(scale_q)) && (trem_q < SIDE_W'(scale_q));

	assign accept       = in_valid && !in_stall;
	assign col_last     = col_cnt_q == DIM_W'(glyph_w - 1'b1);
	assign row_last     = row_cnt_q == DIM_W'(glyph_h - 1'b1);
	assign col_sub_last = col_sub_q == SC_W'(scale_q - 1'b1);
	assign row_sub_last = row_sub_q == SC_W'(scale_q - 1'b1);
	assign hit          = pixel && (col_cell_q < CELLC_W'(OUT_SIZE))
	                      && (row_cell_q < CELLC_W'(OUT_SIZE));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gsp_pkg::FR_SCALE: begin
				if (!grow) state_d = gsp_pkg::FR_PAD;
			end
			gsp_pkg::FR_PAD: begin
				if (pad_done) state_d = gsp_pkg::FR_RUN;
			end
			gsp_pkg::FR_RUN: begin
				state_d = gsp_pkg::FR_RUN;
			end
			default: state_d = gsp_pkg::FR_SCALE;
		endcase
		if (restart) state_d = gsp_pkg::FR_SCALE;
	end

	// Outputs: stall outside the run state or on a full queue
	always_comb begin
		in_stall = 1'b1;
		unique case (state_q)
			gsp_pkg::FR_RUN: in_stall = fifo_full;
			default:         in_stall = 1'b1;
		endcase
	end

	assign push          = accept && (hit || (col_last && row_last));
	assign cmd_flags.hit = hit;
	assign cmd_flags.eof = col_last && row_last;
	assign cmd_row       = CELL_W'(row_cell_q);
	assign cmd_col       = CELL_W'(col_cell_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsp_pkg::FR_SCALE;
		end else begin
			state_q <= state_d;
		end
	end

	// Setup arithmetic and raster walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= SC_W'(1);
			side_q     <= SIDE_W'(OUT_SIZE);
			lrem_q     <= '0;
			trem_q     <= '0;
			lq_q       <= '0;
			tq_q       <= '0;
			col_cnt_q  <= '0;
			row_cnt_q  <= '0;
			col_sub_q  <= '0;
			row_sub_q  <= '0;
			col_cell_q <= '0;
			row_cell_q <= '0;
		end else if (restart) begin
			scale_q <= SC_W'(1);
			side_q  <= SIDE_W'(OUT_SIZE);
		end else begin
			case (state_q)
				gsp_pkg::FR_SCALE: begin
					// Grow the square one block column at a time
					if (grow) begin
						scale_q <= SC_W'(scale_q + 1'b1);
						side_q  <= SIDE_W'(side_q + SIDE_W'(OUT_SIZE));
					end else begin
						lrem_q <= SIDE_W'((side_q - SIDE_W'(glyph_w)) >> 1);
						trem_q <= SIDE_W'((side_q - SIDE_W'(glyph_h)) >> 1);
						lq_q   <= '0;
						tq_q   <= '0;
					end
				end
				gsp_pkg::FR_PAD: begin
					// Split each pad into whole blocks and a remainder
					if (lrem_q >= SIDE_W'(scale_q)) begin
						lrem_q <= SIDE_W'(lrem_q - SIDE_W'(scale_q));
						lq_q   <= CELLC_W'(lq_q + 1'b1);
					end
					if (trem_q >= SIDE_W'(scale_q)) begin
						trem_q <= SIDE_W'(trem_q - SIDE_W'(scale_q));
						tq_q   <= CELLC_W'(tq_q + 1'b1);
					end
					if (pad_done) begin
						col_cnt_q  <= '0;
						row_cnt_q  <= '0;
						col_cell_q <= lq_q;
						row_cell_q <= tq_q;
						col_sub_q  <= SC_W'(lrem_q);
						row_sub_q  <= SC_W'(trem_q);
					end
				end
				gsp_pkg::FR_RUN: begin
					if (accept) begin
						if (col_last) begin
							// Wrap to the next raster row
							col_cnt_q  <= '0;
							col_cell_q <= lq_q;
							col_sub_q  <= SC_W'(lrem_q);
							if (row_last) begin
								row_cnt_q  <= '0;
								row_cell_q <= tq_q;
								row_sub_q  <= SC_W'(trem_q);
							end else begin
								row_cnt_q <= DIM_W'(row_cnt_q + 1'b1);
								if (row_sub_last) begin
									row_sub_q  <= '0;
									row_cell_q <= CELLC_W'(row_cell_q + 1'b1);
								end else begin
									row_sub_q <= SC_W'(row_sub_q + 1'b1);
								end
							end
						end else begin
							col_cnt_q <= DIM_W'(col_cnt_q + 1'b1);
							if (col_sub_last) begin
								col_sub_q  <= '0;
								col_cell_q <= CELLC_W'(col_cell_q + 1'b1);
							end else begin
								col_sub_q <= SC_W'(col_sub_q + 1'b1);
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_accept_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == gsp_pkg::FR_RUN) && !fifo_full)
		else $error("pixel beat taken outside the run state");

endmodule

// File: sv/gsp_back.sv
module gsp_back #(
	parameter int OUT_SIZE = gsp_pkg::OUT_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            restart,
	input  logic                            empty,
	output logic                            pop,
	input  gsp_pkg::gsp_flags_t             cmd_flags,
	input  logic [CELL_W-1:0]               cmd_row,
	input  logic [CELL_W-1:0]               cmd_col,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [gsp_pkg::ROW_BITS_W-1:0]  row_bits,
	output logic [gsp_pkg::ROW_IDX_W-1:0]   row_index,
	output logic                            last_row
);

	localparam int CELL_W = $clog2(OUT_SIZE);

	gsp_pkg::bk_state_t state_q, state_d;

	logic [OUT_SIZE-1:0] grid_q [OUT_SIZE];
	logic [CELL_W-1:0]   dump_cnt_q;
	logic                out_valid_q;
	logic [gsp_pkg::ROW_BITS_W-1:0] out_bits_q;
	logic [gsp_pkg::ROW_IDX_W-1:0]  out_idx_q;
	logic                out_last_q;

	logic out_free;
	logic load;
	logic set_bit;
	logic dump_last;

	assign out_free  = !out_valid_q || !out_stall;
	assign dump_last = dump_cnt_q == CELL_W'(OUT_SIZE - 1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gsp_pkg::BK_RUN: begin
				if (pop && cmd_flags.eof) state_d = gsp_pkg::BK_DUMP;
			end
			gsp_pkg::BK_DUMP: begin
				if (load && dump_last) state_d = gsp_pkg::BK_RUN;
			end
			default: state_d = gsp_pkg::BK_RUN;
		endcase
		if (restart) state_d = gsp_pkg::BK_RUN;
	end

	// Outputs: pop commands while running, load rows while dumping
	always_comb begin
		pop  = 1'b0;
		load = 1'b0;
		unique case (state_q)
			gsp_pkg::BK_RUN:  pop  = !empty && !restart;
			gsp_pkg::BK_DUMP: load = out_free && !restart;
			default: begin
				pop  = 1'b0;
				load = 1'b0;
			end
		endcase
	end

	assign set_bit = pop && cmd_flags.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gsp_pkg::BK_RUN;
			dump_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				dump_cnt_q <= '0;
			end else if (load) begin
				dump_cnt_q <= dump_last ? '0 : CELL_W'(dump_cnt_q + 1'b1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Grid: OR in ink, shift rows out on dump, clear on restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < OUT_SIZE; r++) begin
				grid_q[r] <= '0;
			end
		end else if (restart) begin
			for (int r = 0; r < OUT_SIZE; r++) begin
				grid_q[r] <= '0;
			end
		end else if (load) begin
			for (int r = 0; r < OUT_SIZE - 1; r++) begin
				grid_q[r] <= grid_q[r+1];
			end
			grid_q[OUT_SIZE-1] <= '0;
		end else if (set_bit) begin
			for (int r = 0; r < OUT_SIZE; r++) begin
				if (cmd_row == CELL_W'(r)) begin
					grid_q[r][cmd_col] <= 1'b1;
				end
			end
		end
	end

	// Hold the row beat until taken
	always_ff @(posedge clk) begin
		if (load) begin
			out_bits_q <= gsp_pkg::ROW_BITS_W'(grid_q[0]);
			out_idx_q  <= gsp_pkg::ROW_IDX_W'(dump_cnt_q);
			out_last_q <= dump_last;
		end
	end

	assign out_valid = out_valid_q;
	assign row_bits  = out_bits_q;
	assign row_index = out_idx_q;
	assign last_row  = out_last_q;

	a_no_pop_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gsp_pkg::BK_DUMP |-> !pop)
		else $error("command popped during row dump");

	a_load_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q && (out_last_q == (out_idx_q == gsp_pkg::ROW_IDX_W'(OUT_SIZE - 1))))
		else $error("row beat missing or last flag off");

endmodule

// File: sv/glyph_square_pad_or_pool_core.sv
// Pixel beats: one per cycle while the front is in its run state and the command queue is not
// full; a pixel is queued on accept and folded into the grid when the back pops it.
// Frame end: OUT_SIZE row beats follow the last pixel, one per cycle from the back dump while
// out_stall is low; pixels of the next frame keep flowing into the queue until it is full.
// After reset or a size write the front stalls input during setup: scale search, then pad split.
// Reset: sizes 16 x 16, grid clear, counters zero; a size write also drops a frame in progress.
module glyph_square_pad_or_pool_core #(
	parameter int OUT_SIZE = gsp_pkg::OUT_SIZE_DEF,
	parameter int MAX_SIDE = gsp_pkg::MAX_SIDE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gsp_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [gsp_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [gsp_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            pixel,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [gsp_pkg::ROW_BITS_W-1:0]  row_bits,
	output logic [gsp_pkg::ROW_IDX_W-1:0]   row_index,
	output logic                            last_row
);

	localparam int DIMV_W = $clog2(MAX_SIDE + 1);
	localparam int CW     = (DIMV_W > gsp_pkg::CFG_W) ? DIMV_W : gsp_pkg::CFG_W;
	localparam int CELL_W = $clog2(OUT_SIZE);
	localparam int CMD_W  = 2 + 2 * CELL_W;

	logic [gsp_pkg::CFG_W-1:0] glyph_width_q, glyph_height_q;
	logic                      cfg_wr;
	logic [CW-1:0]             w_ext, h_ext;
	logic [DIMV_W-1:0]         glyph_w, glyph_h;

	gsp_pkg::gsp_flags_t fr_flags, bk_flags;
	logic [CELL_W-1:0]   fr_row, fr_col, bk_row, bk_col;
	logic                push, pop, fifo_full, fifo_empty;
	logic [CMD_W-1:0]    fifo_rd;

	// Register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q  <= gsp_pkg::GLYPH_SIZE_RST;
			glyph_height_q <= gsp_pkg::GLYPH_SIZE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == gsp_pkg::REG_WIDTH) begin
				glyph_width_q <= pwdata[gsp_pkg::CFG_W-1:0];
			end
			if (paddr[2] == gsp_pkg::REG_HEIGHT) begin
				glyph_height_q <= pwdata[gsp_pkg::CFG_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[2])
			gsp_pkg::REG_WIDTH:  prdata = gsp_pkg::APB_DATA_W'(glyph_width_q);
			gsp_pkg::REG_HEIGHT: prdata = gsp_pkg::APB_DATA_W'(glyph_height_q);
			default:             prdata = '0;
		endcase
	end

	// Clamp sizes into 1..MAX_SIDE
	assign w_ext = CW'(glyph_width_q);
	assign h_ext = CW'(glyph_height_q);

	always_comb begin
		if (w_ext == '0) glyph_w = DIMV_W'(1);
		else if (w_ext > CW'(MAX_SIDE)) glyph_w = DIMV_W'(MAX_SIDE);
		else glyph_w = DIMV_W'(w_ext);
		if (h_ext == '0) glyph_h = DIMV_W'(1);
		else if (h_ext > CW'(MAX_SIDE)) glyph_h = DIMV_W'(MAX_SIDE);
		else glyph_h = DIMV_W'(h_ext);
	end

	gsp_front #(
		.OUT_SIZE(OUT_SIZE),
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_wr),
		.glyph_w   (glyph_w),
		.glyph_h   (glyph_h),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.fifo_full (fifo_full),
		.push      (push),
		.cmd_flags (fr_flags),
		.cmd_row   (fr_row),
		.cmd_col   (fr_col)
	);

	gsp_fifo #(
		.DATA_W(CMD_W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.flush   (cfg_wr),
		.push    (push),
		.wr_data ({fr_flags, fr_row, fr_col}),
		.pop     (pop),
		.rd_data (fifo_rd),
		.full    (fifo_full),
		.empty   (fifo_empty)
	);

	assign bk_flags = gsp_pkg::gsp_flags_t'(fifo_rd[CMD_W-1 -: 2]);
	assign bk_row   = fifo_rd[2*CELL_W-1 -: CELL_W];
	assign bk_col   = fifo_rd[CELL_W-1:0];

	gsp_back #(
		.OUT_SIZE(OUT_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_wr),
		.empty     (fifo_empty),
		.pop       (pop),
		.cmd_flags (bk_flags),
		.cmd_row   (bk_row),
		.cmd_col   (bk_col),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.row_bits  (row_bits),
		.row_index (row_index),
		.last_row  (last_row)
	);

endmodule
